/* design/gdwu_pkg.sv */
package gdwu_pkg;

  localparam int unsigned DayW   = 6;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DimW   = 5;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned WdW    = 3;
  localparam int unsigned CentW  = 8;   // year / 100 for a 14-bit year stays below 164
  localparam int unsigned RemW   = 7;   // year % 100

  localparam logic [YearW-1:0] EpochYear = 14'd1900;
  localparam logic [YearW-1:0] MaxYear   = 14'd9999;

  // year / 100 == (year * Recip100) >> Recip100Shift for every 14-bit year
  localparam int unsigned      Recip100Shift = 19;
  localparam int unsigned      ProdW         = 27;
  localparam logic [ProdW-1:0] Recip100      = 27'd5243;

  // leap years in 1..1899
  localparam logic [YearW-1:0] LeapsBeforeEpoch = 14'd460;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [WdW-1:0] WdSunday   = 3'd0;
  localparam logic [WdW-1:0] WdSaturday = 3'd6;
  localparam logic [WdW-1:0] DaysInWeek = 3'd7;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef struct packed {
    date_t            date;
    logic [CentW-1:0] cent;
  } year_split_t;

  typedef struct packed {
    logic             date_valid;
    logic             weekday_valid;
    logic [DimW-1:0]  days_in_month;
    logic [DoyW-1:0]  day_of_year;
    logic [YearW-1:0] year;
    logic [CentW-1:0] cent_prev;     // (year - 1) / 100
  } date_info_t;

  typedef struct packed {
    logic             date_valid;
    logic             weekday_valid;
    logic [DimW-1:0]  days_in_month;
    logic [DoyW-1:0]  day_of_year;
    logic [YearW-1:0] day_count;
  } day_count_t;

  typedef struct packed {
    logic             date_valid;
    logic [DimW-1:0]  days_in_month;
    logic [DoyW-1:0]  day_of_year;
    logic             weekday_valid;
    logic [WdW-1:0]   weekday;
    logic             weekend;
  } result_t;

  function automatic logic [DimW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DimW-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] month);
    logic [DoyW-1:0] d;
    case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // 8 is 1 mod 7: fold octal digits twice, then one subtract
  function automatic logic [WdW-1:0] mod7(input logic [YearW-1:0] v);
    logic [4:0] a;
    logic [3:0] b;
    logic [3:0] r;
    a = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[11:9]) + 5'(v[13:12]);
    b = 4'(a[2:0]) + 4'(a[4:3]);
    r = (b >= 4'(DaysInWeek)) ? b - 4'(DaysInWeek) : b;
    return r[WdW-1:0];
  endfunction

endpackage

/* design/gdwu_date_if.sv */
interface gdwu_date_if;
  import gdwu_pkg::*;

  logic              valid;
  logic              ready;
  logic [DayW-1:0]   day;
  logic [MonthW-1:0] month;
  logic [YearW-1:0]  year;

  modport source (output valid, output day, output month, output year, input ready);
  modport sink   (input valid, input day, input month, input year, output ready);
endinterface

/* design/gdwu_result_if.sv */
interface gdwu_result_if;
  import gdwu_pkg::*;

  logic            valid;
  logic            ready;
  logic            date_valid;
  logic [DimW-1:0] days_in_month;
  logic [DoyW-1:0] day_of_year;
  logic            weekday_valid;
  logic [WdW-1:0]  weekday;
  logic            weekend;

  modport source (output valid, output date_valid, output days_in_month,
                  output day_of_year, output weekday_valid, output weekday,
                  output weekend, input ready);
  modport sink   (input valid, input date_valid, input days_in_month,
                  input day_of_year, input weekday_valid, input weekday,
                  input weekend, output ready);
endinterface

/* design/gdwu_year_stage.sv */
module gdwu_year_stage import gdwu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  date_t       data_i,
  output logic        valid_o,
  output year_split_t data_o
);

  logic              valid_q;
  year_split_t       data_d, data_q;
  logic [ProdW-1:0]  prod;

  // divide by 100 through the reciprocal
  assign prod        = ProdW'(data_i.year) * Recip100;
  assign data_d.date = data_i;
  assign data_d.cent = prod[Recip100Shift +: CentW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/gdwu_date_stage.sv */
module gdwu_date_stage import gdwu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  year_split_t data_i,
  output logic        valid_o,
  output date_info_t  data_o
);

  logic             valid_q;
  date_info_t       data_d, data_q;
  logic [YearW-1:0] rem_wide;
  logic [RemW-1:0]  rem;
  logic             cent_year;
  logic             leap;
  logic [DimW-1:0]  dim;
  logic             ok;
  logic [DoyW-1:0]  doy;

  assign rem_wide  = data_i.date.year - YearW'(data_i.cent) * YearW'(100);
  assign rem       = rem_wide[RemW-1:0];
  assign cent_year = (rem == '0);
  assign leap      = cent_year ? (data_i.cent[1:0] == 2'd0)
                               : (data_i.date.year[1:0] == 2'd0);
  assign dim       = month_len(data_i.date.month, leap);

  assign ok = (data_i.date.day != '0) &&
              (data_i.date.month >= MonthJan) && (data_i.date.month <= MonthDec) &&
              (data_i.date.year != '0) && (data_i.date.year <= MaxYear) &&
              (data_i.date.day <= DayW'(dim));

  assign doy = days_before(data_i.date.month) + DoyW'(data_i.date.day) +
               DoyW'(leap && (data_i.date.month > MonthFeb));

  always_comb begin
    data_d               = '0;
    data_d.date_valid    = ok;
    data_d.weekday_valid = ok && (data_i.date.year >= EpochYear);
    data_d.days_in_month = dim;
    data_d.day_of_year   = ok ? doy : '0;
    data_d.year          = data_i.date.year;
    // the year before a century year falls in the previous century
    data_d.cent_prev     = data_i.cent - CentW'(cent_year);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/gdwu_count_stage.sv */
module gdwu_count_stage import gdwu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  date_info_t data_i,
  output logic       valid_o,
  output day_count_t data_o
);

  logic             valid_q;
  day_count_t       data_d, data_q;
  logic [YearW-1:0] prev_year;
  logic [YearW-1:0] leaps;

  // wraps for years before the epoch; only used when the weekday is valid
  assign prev_year = data_i.year - YearW'(1);
  assign leaps     = (prev_year >> 2) - YearW'(data_i.cent_prev) +
                     YearW'(data_i.cent_prev >> 2);

  always_comb begin
    data_d.date_valid    = data_i.date_valid;
    data_d.weekday_valid = data_i.weekday_valid;
    data_d.days_in_month = data_i.days_in_month;
    data_d.day_of_year   = data_i.day_of_year;
    // 365 is 1 mod 7, so one day per elapsed year is enough
    data_d.day_count     = (data_i.year - EpochYear) + leaps - LeapsBeforeEpoch +
                           YearW'(data_i.day_of_year);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/gdwu_weekday_stage.sv */
module gdwu_weekday_stage import gdwu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  day_count_t data_i,
  output logic       valid_o,
  output result_t    data_o
);

  logic           valid_q;
  result_t        data_d, data_q;
  logic [WdW-1:0] wd;

  assign wd = data_i.weekday_valid ? mod7(data_i.day_count) : WdSunday;

  always_comb begin
    data_d.date_valid    = data_i.date_valid;
    data_d.days_in_month = data_i.days_in_month;
    data_d.day_of_year   = data_i.day_of_year;
    data_d.weekday_valid = data_i.weekday_valid;
    data_d.weekday       = wd;
    data_d.weekend       = data_i.weekday_valid && ((wd == WdSunday) || (wd == WdSaturday));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/gregorian_date_weekday_unit.sv */
// Gregorian date unit. Each date word (day, month, year) yields one result
// word with a validity flag, the month length, the day of the year, and -
// for valid dates from 1900 on - the weekday (0 Sunday .. 6 Saturday) and a
// weekend flag. A date is valid for years 1 to 9999; the month length is
// given for any year (year 0 counts as leap) and is 0 for a month outside
// 1 to 12. Invalid dates give 0 for day of year, weekday and flags. The unit
// takes one date every cycle and returns its result through four register
// stages: split of the year by 100 (reciprocal multiply), leap rule and
// month tables, day count since the epoch, and the weekday reduction
// modulo 7 into the output register. Backpressure from the result side
// holds every stage; a stage that is empty or moving on still takes a new
// word.
module gregorian_date_weekday_unit import gdwu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  gdwu_date_if.sink     date_i,
  gdwu_result_if.source result_o
);

  logic        v1, v2, v3, v4;
  logic        en1, en2, en3, en4;
  date_t       in_word;
  year_split_t s1;
  date_info_t  s2;
  day_count_t  s3;
  result_t     s4;

  // advance a stage when it is empty or its successor advances
  assign en4 = !v4 || result_o.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign date_i.ready = en1;

  assign in_word.day   = date_i.day;
  assign in_word.month = date_i.month;
  assign in_word.year  = date_i.year;

  gdwu_year_stage u_year (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (date_i.valid),
    .data_i  (in_word),
    .valid_o (v1),
    .data_o  (s1)
  );

  gdwu_date_stage u_date (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (s1),
    .valid_o (v2),
    .data_o  (s2)
  );

  gdwu_count_stage u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .data_i  (s2),
    .valid_o (v3),
    .data_o  (s3)
  );

  gdwu_weekday_stage u_weekday (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en4),
    .valid_i (v3),
    .data_i  (s3),
    .valid_o (v4),
    .data_o  (s4)
  );

  // drive the result word straight from the last stage register
  assign result_o.valid         = v4;
  assign result_o.date_valid    = s4.date_valid;
  assign result_o.days_in_month = s4.days_in_month;
  assign result_o.day_of_year   = s4.day_of_year;
  assign result_o.weekday_valid = s4.weekday_valid;
  assign result_o.weekday       = s4.weekday;
  assign result_o.weekend       = s4.weekend;

  // a weekday is only ever given for a valid date
  a_wd_needs_date : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.weekday_valid |-> result_o.date_valid)
    else $error("weekday flagged valid for an invalid date");

  // day of year is non-zero exactly for valid dates
  a_doy_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> ((result_o.day_of_year != '0) == result_o.date_valid))
    else $error("day of year disagrees with date validity");

  // weekday stays within the week and the weekend flag follows it
  a_weekend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.weekday <= WdSaturday) &&
      (result_o.weekend == (result_o.weekday_valid &&
        ((result_o.weekday == WdSunday) || (result_o.weekday == WdSaturday)))))
    else $error("weekday out of range or weekend flag inconsistent");

  // a stalled pipeline takes no new word once all stages are full
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1 && v2 && v3 && v4 && !result_o.ready |-> !date_i.ready)
    else $error("input accepted while the pipeline is full and stalled");

endmodule
